@@ design/assert_macros.svh @@
// Assertion helpers for the top-level file that checks this design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

@@ design/btlo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlo_pkg
// Shared types and constants for the bottom-up level-order tree lister.
// ----------------------------------------------------------------------------
package btlo_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int ID_BITS_DEF   = 16;
    localparam int DEPTH_W       = 10;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RT_CHK,
        S_RT_CAND,
        S_RQ_CHK,
        S_RQ_CMP,
        S_APP_ROOT,
        S_BFS_CHK,
        S_BFS_ND,
        S_SR_CHK,
        S_SR_CMP,
        S_BFS_KID,
        S_APP1,
        S_APP2,
        S_SEG_INIT,
        S_SEG_REF,
        S_SEG_SCAN,
        S_SEG_CMP,
        S_FT_RD,
        S_FT_OUT
    } t_state;

    // Address source for the child-store read port.
    typedef enum logic [1:0] {
        KID_R,
        KID_Q,
        KID_ROOT
    } t_kid_sel;

    // Address source for the listing-store read port.
    typedef enum logic [1:0] {
        ORD_I,
        ORD_K,
        ORD_END,
        ORD_S
    } t_ord_sel;

    typedef struct packed {
        logic     load;
        logic     walk_init;
        logic     cap_cand;
        logic     q_clr;
        logic     q_inc;
        logic     r_clr;
        logic     r_inc;
        logic     root_hit;
        logic     app_root;
        logic     cap_cur;
        logic     cap_kids;
        logic     clr_kids;
        logic     app1;
        logic     app2;
        logic     i_inc;
        logic     seg_start;
        logic     cap_ref;
        logic     s_dec;
        logic     set_k;
        logic     out_empty;
        logic     out_data;
        logic     k_inc;
        logic     end_to_s;
        t_kid_sel kid_sel;
        t_ord_sel ord_sel;
    } t_cmd;

    typedef struct packed {
        logic listing;
        logic found;
        logic r_at_cnt;
        logic q_at_cnt;
        logic kid_hit;
        logic node_match;
        logic i_at_oc;
        logic i_zero;
        logic k1_nz;
        logic k2_nz;
        logic full;
        logic end_zero;
        logic s_zero;
        logic depth_eq;
        logic k_last;
    } t_status;

endpackage

@@ design/binary_tree_level_order_bottom_up.sv @@
`timescale 1ns / 1ps
// Load: accepted while idle, busy stays low. The first fetch runs the walk: a root search over
// the records, then a breadth-first walk with a record search for each node below the root,
// then the fetch. Later fetches read the stored listing; after the final node of a level they
// also scan back for the start of the next shallower level. No listing gives an empty word.
// The word shows for one cycle right after the output step; results cannot be stalled.
// Synchronous active-low reset returns to loading.
// ----------------------------------------------------------------------------
// binary_tree_level_order_bottom_up
// Loads tree records and lists the nodes deepest level first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_tree_level_order_bottom_up #(
    parameter int MAX_NODES = btlo_pkg::MAX_NODES_DEF,
    parameter int ID_BITS   = btlo_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [ID_BITS-1:0]           i_node_id,
    input  logic [ID_BITS-1:0]           i_first_child,
    input  logic [ID_BITS-1:0]           i_second_child,
    output logic                         o_done,
    output logic                         o_valid_res,
    output logic [btlo_pkg::DEPTH_W-1:0] o_depth,
    output logic [ID_BITS-1:0]           o_result_node,
    output logic                         o_level_end,
    output logic                         o_last,
    output logic                         o_overflow
);
    btlo_pkg::t_cmd    cmd;
    btlo_pkg::t_status sts;

    btlo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_action(i_action),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    btlo_dp #(
        .MAX_NODES(MAX_NODES),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_node_id     (i_node_id),
        .i_first_child (i_first_child),
        .i_second_child(i_second_child),
        .o_done        (o_done),
        .o_valid_res   (o_valid_res),
        .o_depth       (o_depth),
        .o_result_node (o_result_node),
        .o_level_end   (o_level_end),
        .o_last        (o_last),
        .o_overflow    (o_overflow)
    );

    `ASSERT_NEXT(a_fetch_goes_busy, i_clk, i_rst_n, start && !busy && i_action, busy)
    `ASSERT_NEXT(a_word_after_output, i_clk, i_rst_n, cmd.out_data || cmd.out_empty, o_done)
    `ASSERT_IMPL(a_last_ends_level, i_clk, i_rst_n, o_done && o_last, o_level_end && o_valid_res)
    `ASSERT_IMPL(a_empty_word_clean, i_clk, i_rst_n, o_done && !o_valid_res, !o_last && !o_level_end && o_depth == '0)

endmodule

@@ design/btlo_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlo_dp
// Datapath: record and listing memories, counters, compares, result register.
// ----------------------------------------------------------------------------
module btlo_dp #(
    parameter int MAX_NODES = btlo_pkg::MAX_NODES_DEF,
    parameter int ID_BITS   = btlo_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  btlo_pkg::t_cmd              i_cmd,
    output btlo_pkg::t_status           o_sts,
    input  logic [ID_BITS-1:0]          i_node_id,
    input  logic [ID_BITS-1:0]          i_first_child,
    input  logic [ID_BITS-1:0]          i_second_child,
    output logic                        o_done,
    output logic                        o_valid_res,
    output logic [btlo_pkg::DEPTH_W-1:0] o_depth,
    output logic [ID_BITS-1:0]          o_result_node,
    output logic                        o_level_end,
    output logic                        o_last,
    output logic                        o_overflow
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = btlo_pkg::DEPTH_W;
    localparam logic [CW-1:0] CAP = CW'(MAX_NODES);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [ID_BITS-1:0] mem_node   [MAX_NODES];
    logic [ID_BITS-1:0] mem_first  [MAX_NODES];
    logic [ID_BITS-1:0] mem_second [MAX_NODES];
    logic [ID_BITS-1:0] mem_onode  [MAX_NODES];
    logic [DW-1:0]      mem_odepth [MAX_NODES];

    logic [ID_BITS-1:0] r_node_q, r_first_q, r_second_q, r_onode_q;
    logic [DW-1:0]      r_odepth_q;

    logic [CW-1:0] r_rec_cnt, r_oc, r_r, r_q, r_i, r_k, r_s, r_end;
    logic [AW-1:0] r_root;
    logic          r_found, r_listing, r_ovf;
    logic [ID_BITS-1:0] r_cand, r_root_node, r_cur, r_kid1, r_kid2;
    logic [DW-1:0] r_cur_depth, r_ref;

    logic          r_done, r_valid_res, r_level_end, r_last, r_ovf_o;
    logic [DW-1:0] r_depth;
    logic [ID_BITS-1:0] r_result;

    logic [AW-1:0] kid_addr, ord_addr;
    logic [CW-1:0] end_m1, s_m1, k_p1;
    logic [DW-1:0] next_depth;
    logic          full, app_wr;
    logic [ID_BITS-1:0] app_id;
    logic          load_wr;

    assign end_m1 = r_end - ONE;
    assign s_m1   = r_s - ONE;
    assign k_p1   = r_k + ONE;
    assign full   = (r_oc == CAP);
    assign next_depth = (r_cur_depth == btlo_pkg::DEPTH_MAX) ? r_cur_depth
                                                             : r_cur_depth + DW'(1);

    always_comb begin
        case (i_cmd.kid_sel)
            btlo_pkg::KID_Q:    kid_addr = r_q[AW-1:0];
            btlo_pkg::KID_ROOT: kid_addr = r_root;
            default:            kid_addr = r_r[AW-1:0];
        endcase
        case (i_cmd.ord_sel)
            btlo_pkg::ORD_K:   ord_addr = r_k[AW-1:0];
            btlo_pkg::ORD_END: ord_addr = end_m1[AW-1:0];
            btlo_pkg::ORD_S:   ord_addr = s_m1[AW-1:0];
            default:           ord_addr = r_i[AW-1:0];
        endcase
    end

    assign load_wr = i_cmd.load && !r_listing && (i_node_id != '0) && (r_rec_cnt != CAP);
    assign app_wr  = (i_cmd.app1 && (r_kid1 != '0) && !full) ||
                     (i_cmd.app2 && (r_kid2 != '0) && !full) || i_cmd.app_root;
    assign app_id  = i_cmd.app_root ? r_root_node : (i_cmd.app1 ? r_kid1 : r_kid2);

    // Record stores: written on load, read every cycle.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem_node[r_rec_cnt[AW-1:0]]   <= i_node_id;
            mem_first[r_rec_cnt[AW-1:0]]  <= i_first_child;
            mem_second[r_rec_cnt[AW-1:0]] <= i_second_child;
        end
        r_node_q   <= mem_node[r_r[AW-1:0]];
        r_first_q  <= mem_first[kid_addr];
        r_second_q <= mem_second[kid_addr];
    end

    // Listing stores: breadth-first queue.
    always_ff @(posedge i_clk) begin
        if (app_wr) begin
            mem_onode[r_oc[AW-1:0]]  <= app_id;
            mem_odepth[r_oc[AW-1:0]] <= i_cmd.app_root ? '0 : next_depth;
        end
        r_onode_q  <= mem_onode[ord_addr];
        r_odepth_q <= mem_odepth[ord_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt <= '0;
            r_oc      <= '0;
            r_r       <= '0;
            r_q       <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_s       <= '0;
            r_end     <= '0;
            r_found   <= 1'b0;
            r_listing <= 1'b0;
            r_ovf     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.out_empty || i_cmd.out_data;
            if (load_wr) begin
                r_rec_cnt <= r_rec_cnt + ONE;
            end
            if (i_cmd.load && !r_listing && (i_node_id != '0) && (r_rec_cnt == CAP)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_listing <= 1'b1;
                r_oc      <= '0;
                r_found   <= 1'b0;
            end
            if (i_cmd.walk_init || i_cmd.r_clr) begin
                r_r <= '0;
            end else if (i_cmd.r_inc) begin
                r_r <= r_r + ONE;
            end
            if (i_cmd.q_clr) begin
                r_q <= '0;
            end else if (i_cmd.q_inc) begin
                r_q <= r_q + ONE;
            end
            if (i_cmd.root_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.app_root) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + ONE;
            end
            if (app_wr) begin
                r_oc <= r_oc + ONE;
            end
            if ((i_cmd.app1 && (r_kid1 != '0) && full) ||
                (i_cmd.app2 && (r_kid2 != '0) && full)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.seg_start) begin
                r_end <= r_oc;
            end else if (i_cmd.end_to_s) begin
                r_end <= r_s;
            end
            if (i_cmd.cap_ref) begin
                r_s <= end_m1;
            end else if (i_cmd.s_dec) begin
                r_s <= s_m1;
            end
            if (i_cmd.set_k) begin
                r_k <= r_s;
            end else if (i_cmd.k_inc) begin
                r_k <= k_p1;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_cand) begin
            r_cand <= r_node_q;
        end
        if (i_cmd.root_hit) begin
            r_root      <= r_r[AW-1:0];
            r_root_node <= r_cand;
        end
        if (i_cmd.cap_cur) begin
            r_cur       <= r_onode_q;
            r_cur_depth <= r_odepth_q;
        end
        if (i_cmd.cap_kids) begin
            r_kid1 <= r_first_q;
            r_kid2 <= r_second_q;
        end else if (i_cmd.clr_kids) begin
            r_kid1 <= '0;
            r_kid2 <= '0;
        end
        if (i_cmd.cap_ref) begin
            r_ref <= r_odepth_q;
        end
        if (i_cmd.out_data) begin
            r_valid_res <= 1'b1;
            r_depth     <= r_odepth_q;
            r_result    <= r_onode_q;
            r_level_end <= (k_p1 == r_end);
            r_last      <= (k_p1 == r_end) && (r_s == '0);
            r_ovf_o     <= r_ovf;
        end else if (i_cmd.out_empty) begin
            r_valid_res <= 1'b0;
            r_depth     <= '0;
            r_result    <= '0;
            r_level_end <= 1'b0;
            r_last      <= 1'b0;
            r_ovf_o     <= r_ovf;
        end
    end

    always_comb begin
        o_sts.listing    = r_listing;
        o_sts.found      = r_found;
        o_sts.r_at_cnt   = (r_r == r_rec_cnt);
        o_sts.q_at_cnt   = (r_q == r_rec_cnt);
        o_sts.kid_hit    = (r_first_q == r_cand) || (r_second_q == r_cand);
        o_sts.node_match = (r_node_q == r_cur);
        o_sts.i_at_oc    = (r_i == r_oc);
        o_sts.i_zero     = (r_i == '0);
        o_sts.k1_nz      = (r_kid1 != '0);
        o_sts.k2_nz      = (r_kid2 != '0);
        o_sts.full       = full;
        o_sts.end_zero   = (r_end == '0);
        o_sts.s_zero     = (r_s == '0);
        o_sts.depth_eq   = (r_odepth_q == r_ref);
        o_sts.k_last     = (k_p1 == r_end);
    end

    assign o_done        = r_done;
    assign o_valid_res   = r_valid_res;
    assign o_depth       = r_depth;
    assign o_result_node = r_result;
    assign o_level_end   = r_level_end;
    assign o_last        = r_last;
    assign o_overflow    = r_ovf_o;

endmodule

@@ design/btlo_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlo_ctrl
// Controller: sequences root search, breadth-first walk, level scan and fetch.
// ----------------------------------------------------------------------------
module btlo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_action,
    input  btlo_pkg::t_status i_sts,
    output btlo_pkg::t_cmd    o_cmd,
    output logic              busy
);
    btlo_pkg::t_state r_state, n_state;
    logic             r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btlo_pkg::S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pend        = r_pend;
        o_cmd         = '0;
        o_cmd.kid_sel = btlo_pkg::KID_R;
        o_cmd.ord_sel = btlo_pkg::ORD_I;
        unique case (r_state)
            btlo_pkg::S_IDLE: begin
                if (start) begin
                    if (i_action == btlo_pkg::ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_sts.listing) begin
                        n_state = btlo_pkg::S_FT_RD;
                    end else begin
                        o_cmd.walk_init = 1'b1;
                        n_pend          = 1'b1;
                        n_state         = btlo_pkg::S_RT_CHK;
                    end
                end
            end
            btlo_pkg::S_RT_CHK: begin
                if (i_sts.r_at_cnt) begin
                    if (i_sts.found) begin
                        n_state = btlo_pkg::S_APP_ROOT;
                    end else begin
                        o_cmd.seg_start = 1'b1;
                        n_state         = btlo_pkg::S_SEG_INIT;
                    end
                end else begin
                    n_state = btlo_pkg::S_RT_CAND;
                end
            end
            btlo_pkg::S_RT_CAND: begin
                o_cmd.cap_cand = 1'b1;
                o_cmd.q_clr    = 1'b1;
                n_state        = btlo_pkg::S_RQ_CHK;
            end
            btlo_pkg::S_RQ_CHK: begin
                o_cmd.kid_sel = btlo_pkg::KID_Q;
                if (i_sts.q_at_cnt) begin
                    // No record names the candidate as a child: latest root so far.
                    o_cmd.root_hit = 1'b1;
                    o_cmd.r_inc    = 1'b1;
                    n_state        = btlo_pkg::S_RT_CHK;
                end else begin
                    n_state = btlo_pkg::S_RQ_CMP;
                end
            end
            btlo_pkg::S_RQ_CMP: begin
                if (i_sts.kid_hit) begin
                    o_cmd.r_inc = 1'b1;
                    n_state     = btlo_pkg::S_RT_CHK;
                end else begin
                    o_cmd.q_inc = 1'b1;
                    n_state     = btlo_pkg::S_RQ_CHK;
                end
            end
            btlo_pkg::S_APP_ROOT: begin
                o_cmd.app_root = 1'b1;
                n_state        = btlo_pkg::S_BFS_CHK;
            end
            btlo_pkg::S_BFS_CHK: begin
                o_cmd.ord_sel = btlo_pkg::ORD_I;
                if (i_sts.i_at_oc) begin
                    o_cmd.seg_start = 1'b1;
                    n_state         = btlo_pkg::S_SEG_INIT;
                end else begin
                    n_state = btlo_pkg::S_BFS_ND;
                end
            end
            btlo_pkg::S_BFS_ND: begin
                o_cmd.cap_cur = 1'b1;
                if (i_sts.i_zero) begin
                    // The root takes its children from its own record.
                    o_cmd.kid_sel = btlo_pkg::KID_ROOT;
                    n_state       = btlo_pkg::S_BFS_KID;
                end else begin
                    o_cmd.r_clr = 1'b1;
                    n_state     = btlo_pkg::S_SR_CHK;
                end
            end
            btlo_pkg::S_SR_CHK: begin
                o_cmd.kid_sel = btlo_pkg::KID_R;
                if (i_sts.r_at_cnt) begin
                    o_cmd.clr_kids = 1'b1;
                    n_state        = btlo_pkg::S_APP1;
                end else begin
                    n_state = btlo_pkg::S_SR_CMP;
                end
            end
            btlo_pkg::S_SR_CMP: begin
                if (i_sts.node_match) begin
                    o_cmd.cap_kids = 1'b1;
                    n_state        = btlo_pkg::S_APP1;
                end else begin
                    o_cmd.r_inc = 1'b1;
                    n_state     = btlo_pkg::S_SR_CHK;
                end
            end
            btlo_pkg::S_BFS_KID: begin
                o_cmd.cap_kids = 1'b1;
                n_state        = btlo_pkg::S_APP1;
            end
            btlo_pkg::S_APP1: begin
                o_cmd.app1 = 1'b1;
                if (i_sts.k1_nz && i_sts.full) begin
                    o_cmd.seg_start = 1'b1;
                    n_state         = btlo_pkg::S_SEG_INIT;
                end else begin
                    n_state = btlo_pkg::S_APP2;
                end
            end
            btlo_pkg::S_APP2: begin
                o_cmd.app2 = 1'b1;
                if (i_sts.k2_nz && i_sts.full) begin
                    o_cmd.seg_start = 1'b1;
                    n_state         = btlo_pkg::S_SEG_INIT;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = btlo_pkg::S_BFS_CHK;
                end
            end
            btlo_pkg::S_SEG_INIT: begin
                o_cmd.ord_sel = btlo_pkg::ORD_END;
                if (i_sts.end_zero) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? btlo_pkg::S_FT_RD : btlo_pkg::S_IDLE;
                end else begin
                    n_state = btlo_pkg::S_SEG_REF;
                end
            end
            btlo_pkg::S_SEG_REF: begin
                o_cmd.cap_ref = 1'b1;
                n_state       = btlo_pkg::S_SEG_SCAN;
            end
            btlo_pkg::S_SEG_SCAN: begin
                o_cmd.ord_sel = btlo_pkg::ORD_S;
                if (i_sts.s_zero) begin
                    o_cmd.set_k = 1'b1;
                    n_pend      = 1'b0;
                    n_state     = r_pend ? btlo_pkg::S_FT_RD : btlo_pkg::S_IDLE;
                end else begin
                    n_state = btlo_pkg::S_SEG_CMP;
                end
            end
            btlo_pkg::S_SEG_CMP: begin
                if (i_sts.depth_eq) begin
                    o_cmd.s_dec = 1'b1;
                    n_state     = btlo_pkg::S_SEG_SCAN;
                end else begin
                    o_cmd.set_k = 1'b1;
                    n_pend      = 1'b0;
                    n_state     = r_pend ? btlo_pkg::S_FT_RD : btlo_pkg::S_IDLE;
                end
            end
            btlo_pkg::S_FT_RD: begin
                o_cmd.ord_sel = btlo_pkg::ORD_K;
                if (i_sts.end_zero) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = btlo_pkg::S_IDLE;
                end else begin
                    n_state = btlo_pkg::S_FT_OUT;
                end
            end
            btlo_pkg::S_FT_OUT: begin
                o_cmd.out_data = 1'b1;
                if (i_sts.k_last) begin
                    // Level finished: find the start of the next shallower level.
                    o_cmd.end_to_s = 1'b1;
                    n_state        = btlo_pkg::S_SEG_INIT;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = btlo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btlo_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != btlo_pkg::S_IDLE);

endmodule
